// ===== hdl/arrowhead_segment_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Arrowhead segment generator assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ARROWHEAD_SEGMENT_GENERATOR_DEFINES_SVH
`define ARROWHEAD_SEGMENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/asg_pkg.sv =====
// ----------------------------------------------------------------------------
// asg_pkg
// Shared types, constants and tables of the arrowhead segment generator.
// ----------------------------------------------------------------------------
`default_nettype none

package asg_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_MAX       = 32;
	localparam int DIV_STEPS        = 30;   // quotient bits of 2^42 / aspect
	localparam int D3_CYCLES        = 8;    // 64-bit magnitude, one byte a cycle
	localparam int CNT_W            = 5;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_TURNS  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 1'd1;
	localparam logic [31:0] TURNS_RESET = 32'd683565276;

	localparam logic [1:0] LEN_FINITE  = 2'd0;
	localparam logic [1:0] LEN_NEG_INF = 2'd2;

	localparam logic [15:0] ASPECT_ONE = 16'd4096;
	localparam logic signed [33:0] X_INIT = 34'sd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PH_LO,
		ST_PH_HI,
		ST_INIT,
		ST_ITER,
		ST_SCALE,
		ST_MUL_C,
		ST_MUL_S,
		ST_D3_INIT,
		ST_DIV3,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             ph_lo;
		logic             ph_hi;
		logic             init;
		logic             cordic_en;
		logic             div_en;
		logic [CNT_W-1:0] idx;
		logic             scale;
		logic             mul_c;
		logic             mul_s;
		logic             d3_init;
		logic             d3_step;
		logic             sum;
		logic             out_load;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/arrowhead_segment_generator.sv =====
// ----------------------------------------------------------------------------
// arrowhead_segment_generator
// Turns a tip, a direction and a length into the three points of an arrowhead.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            content
//  s_axis    in   tvalid/tready        tip, angle, length, aspect; tuser flags
//  m_axis    out  tvalid/tready        left corner, tip, right corner (16b each)
//  cfg       in   cfg_we               turns_per_unit, angle_offset
//
//  One request passes from acceptance to a loaded result through the phase,
//  iteration, scaling, multiply, divide-by-3 and sum states; the longer of the
//  30-step reciprocal divider and the CORDIC loop sets the iteration phase.
//  Requests with the angle flagged special are dropped in their accept cycle.
//  The result register holds while m_axis stalls; the next request is taken
//  meanwhile and waits at the end of its sequence until that register frees.
//  arst_n resets control state, the configuration and the stored length.
// ----------------------------------------------------------------------------
`default_nettype none

module arrowhead_segment_generator #(
	parameter int CORDIC_STEPS = asg_pkg::CORDIC_STEPS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [asg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire [asg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// tip_x[23:0], tip_y[47:24], angle[79:48], arrow_length[103:80],
	// aspect[119:104]
	input  wire [119:0]                     s_axis_tdata,
	// angle_special[0], length_kind[2:1]
	input  wire [2:0]                       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// left_x[15:0], left_y[31:16], point_x[47:32], point_y[63:48],
	// right_x[79:64], right_y[95:80]
	output logic [95:0]                     m_axis_tdata
);
	import asg_pkg::*;

	cmd_t               cmd;
	logic signed [15:0] left_x, left_y, point_x, point_y, right_x, right_y;

	// sequence control and result valid
	asg_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.angle_special(s_axis_tuser[0]),
		.in_ready     (s_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.cmd          (cmd)
	);

	// arithmetic, configuration and stored length
	asg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.tip_x       ($signed(s_axis_tdata[23:0])),
		.tip_y       ($signed(s_axis_tdata[47:24])),
		.angle       ($signed(s_axis_tdata[79:48])),
		.arrow_length($signed(s_axis_tdata[103:80])),
		.length_kind (s_axis_tuser[2:1]),
		.aspect      (s_axis_tdata[119:104]),
		.left_x      (left_x),
		.left_y      (left_y),
		.point_x     (point_x),
		.point_y     (point_y),
		.right_x     (right_x),
		.right_y     (right_y)
	);

	// pack the result, first field lowest
	assign m_axis_tdata = {right_y, right_x, point_y, point_x, left_y, left_x};

endmodule

`default_nettype wire

// ===== hdl/asg_datapath.sv =====
// ----------------------------------------------------------------------------
// asg_datapath
// Phase product, CORDIC, reciprocal divider, scaling, divide-by-3 and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire asg_pkg::cmd_t               cmd,
	input  wire                              cfg_we,
	input  wire [asg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire [asg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire signed [23:0]                tip_x,
	input  wire signed [23:0]                tip_y,
	input  wire signed [31:0]                angle,
	input  wire signed [23:0]                arrow_length,
	input  wire [1:0]                        length_kind,
	input  wire [15:0]                       aspect,
	output logic signed [15:0]               left_x,
	output logic signed [15:0]               left_y,
	output logic signed [15:0]               point_x,
	output logic signed [15:0]               point_y,
	output logic signed [15:0]               right_x,
	output logic signed [15:0]               right_y
);
	import asg_pkg::*;

	function automatic logic [9:0] div3_byte(input logic [1:0] rem_in, input logic [7:0] bits);
		logic [1:0] rem;
		logic [2:0] r;
		logic [7:0] q;
		rem = rem_in;
		q   = '0;
		for (int j = 7; j >= 0; j--) begin
			r = {rem, bits[j]};
			if (r >= 3'd3) begin
				q[j] = 1'b1;
				rem  = 2'(r - 3'd3);
			end else begin
				rem = r[1:0];
			end
		end
		return {rem, q};
	endfunction

	function automatic logic signed [15:0] rnd_sat38(input logic signed [60:0] v);
		logic signed [60:0] w;
		logic signed [60:0] r;
		w = v + (61'sd1 <<< 37);
		if (w[60])
			r = (w + ((61'sd1 <<< 38) - 61'sd1)) >>> 38;
		else
			r = w >>> 38;
		if (r > 61'sd32767)
			return 16'sh7fff;
		else if (r < -61'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] rnd_sat8(input logic signed [23:0] v);
		logic signed [24:0] w;
		logic signed [24:0] r;
		w = 25'(v) + 25'sd128;
		if (w[24])
			r = (w + 25'sd255) >>> 8;
		else
			r = w >>> 8;
		if (r > 25'sd32767)
			return 16'sh7fff;
		else if (r < -25'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	logic [31:0]        turns_q;
	logic signed [31:0] offset_q;
	logic signed [15:0] last_len_q;

	logic signed [23:0] tip_x_q, tip_y_q, len_q;
	logic signed [31:0] angle_q;
	logic [15:0]        asp_q;

	logic [31:0]        phase_q;
	logic               flip_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [16:0]        rem_q;
	logic [29:0]        rcp_q;
	logic signed [33:0] c_q, s_q;
	logic signed [57:0] lc_q, ls_q;
	logic [63:0]        mc_q, ms_q, qc_q, qs_q;
	logic [1:0]         rc_q, rs_q;
	logic signed [60:0] lx_q, ly_q, rx_q, ry_q;

	// length selection at load
	logic signed [15:0] len_trunc;
	logic signed [23:0] len_sel;
	always_comb begin
		len_trunc = arrow_length[23:8] + 16'((arrow_length[23] && (arrow_length[7:0] != 8'd0)));
		if (length_kind == LEN_FINITE)
			len_sel = arrow_length;
		else if (length_kind == LEN_NEG_INF && last_len_q > 16'sd0)
			len_sel = -(24'(last_len_q) <<< 8);
		else
			len_sel = 24'(last_len_q) <<< 8;
	end

	// phase = bits 47..16 of (offset - angle) * turns
	logic signed [32:0] d_ang;
	logic signed [49:0] prod_lo, prod_hi;
	assign d_ang   = 33'(offset_q) - 33'(angle_q);
	assign prod_lo = d_ang * $signed({1'b0, turns_q[15:0]});
	assign prod_hi = d_ang * $signed({1'b0, turns_q[31:16]});

	logic [31:0] ph_rot;
	logic        flip_n;
	assign ph_rot = phase_q + 32'h4000_0000;
	assign flip_n = ph_rot[31];

	// CORDIC step
	logic signed [33:0] sx, sy, atn;
	assign sx  = x_q >>> cmd.idx;
	assign sy  = y_q >>> cmd.idx;
	assign atn = $signed({2'b00, ATAN_TURNS[cmd.idx]});

	logic [16:0] dv_t;
	assign dv_t = {rem_q[15:0], 1'b0};

	// scaling
	logic               big;
	logic signed [33:0] co, si, m_a;
	logic signed [31:0] m_b;
	logic signed [65:0] m_p;
	assign big = asp_q > ASPECT_ONE;
	assign co  = flip_q ? -x_q : x_q;
	assign si  = flip_q ? -y_q : y_q;
	assign m_a = big ? co : si;
	assign m_b = big ? $signed({2'b00, rcp_q}) : $signed({16'd0, asp_q});
	assign m_p = m_a * m_b;

	logic signed [57:0] len_prod;
	assign len_prod = len_q * (cmd.mul_c ? c_q : s_q);

	logic [57:0] abs_c, abs_s;
	assign abs_c = lc_q[57] ? 58'(-lc_q) : 58'(lc_q);
	assign abs_s = ls_q[57] ? 58'(-ls_q) : 58'(ls_q);

	logic [9:0] d3c, d3s;
	assign d3c = div3_byte(rc_q, mc_q[63:56]);
	assign d3s = div3_byte(rs_q, ms_q[63:56]);

	logic signed [57:0] c3, s3;
	assign c3 = lc_q[57] ? -$signed(qc_q[57:0]) : $signed(qc_q[57:0]);
	assign s3 = ls_q[57] ? -$signed(qs_q[57:0]) : $signed(qs_q[57:0]);

	logic signed [60:0] px, py, lc61, ls61, c361, s361;
	assign px   = 61'(tip_x_q) <<< 30;
	assign py   = 61'(tip_y_q) <<< 30;
	assign lc61 = 61'(lc_q);
	assign ls61 = 61'(ls_q);
	assign c361 = 61'(c3);
	assign s361 = 61'(s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turns_q    <= TURNS_RESET;
			offset_q   <= '0;
			last_len_q <= 16'sd1;
		end else begin
			if (cfg_we && cfg_addr == REG_TURNS)
				turns_q <= cfg_wdata;
			if (cfg_we && cfg_addr == REG_OFFSET)
				offset_q <= $signed(cfg_wdata);
			if (cmd.load && length_kind == LEN_FINITE)
				last_len_q <= len_trunc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tip_x_q <= tip_x;
			tip_y_q <= tip_y;
			angle_q <= angle;
			asp_q   <= aspect;
			len_q   <= len_sel;
		end
		if (cmd.ph_lo)
			phase_q <= prod_lo[47:16];
		if (cmd.ph_hi)
			phase_q <= phase_q + prod_hi[31:0];
		if (cmd.init) begin
			flip_q <= flip_n;
			z_q    <= 34'($signed(phase_q ^ {flip_n, 31'd0}));
			x_q    <= X_INIT;
			y_q    <= '0;
			rem_q  <= 17'(ASPECT_ONE);
			rcp_q  <= '0;
		end
		if (cmd.cordic_en) begin
			if (!z_q[33]) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + atn;
			end
		end
		if (cmd.div_en) begin
			if (dv_t >= {1'b0, asp_q}) begin
				rem_q <= dv_t - {1'b0, asp_q};
				rcp_q <= {rcp_q[28:0], 1'b1};
			end else begin
				rem_q <= dv_t;
				rcp_q <= {rcp_q[28:0], 1'b0};
			end
		end
		if (cmd.scale) begin
			c_q <= big ? m_p[63:30] : co;
			s_q <= big ? si : m_p[45:12];
		end
		if (cmd.mul_c)
			lc_q <= len_prod;
		if (cmd.mul_s)
			ls_q <= len_prod;
		if (cmd.d3_init) begin
			mc_q <= 64'(abs_c);
			ms_q <= 64'(abs_s);
			rc_q <= '0;
			rs_q <= '0;
			qc_q <= '0;
			qs_q <= '0;
		end
		if (cmd.d3_step) begin
			mc_q <= mc_q << 8;
			ms_q <= ms_q << 8;
			rc_q <= d3c[9:8];
			rs_q <= d3s[9:8];
			qc_q <= {qc_q[55:0], d3c[7:0]};
			qs_q <= {qs_q[55:0], d3s[7:0]};
		end
		if (cmd.sum) begin
			lx_q <= px - lc61 - s361;
			ly_q <= py - ls61 + c361;
			rx_q <= px - lc61 + s361;
			ry_q <= py - ls61 - c361;
		end
		if (cmd.out_load) begin
			left_x  <= rnd_sat38(lx_q);
			left_y  <= rnd_sat38(ly_q);
			point_x <= rnd_sat8(tip_x_q);
			point_y <= rnd_sat8(tip_y_q);
			right_x <= rnd_sat38(rx_q);
			right_y <= rnd_sat38(ry_q);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/asg_ctrl.sv =====
// ----------------------------------------------------------------------------
// asg_ctrl
// Sequencer that steps the datapath through one request and owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_ctrl #(
	parameter int CORDIC_STEPS = asg_pkg::CORDIC_STEPS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire            angle_special,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	output asg_pkg::cmd_t  cmd
);
	import asg_pkg::*;

	localparam int N_ROT = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
	localparam int N_ITER = (N_ROT > DIV_STEPS) ? N_ROT : DIV_STEPS;

	state_t           state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             iter_last, d3_last, out_free;

	assign iter_last = cnt_q == CNT_W'(N_ITER - 1);
	assign d3_last   = cnt_q == CNT_W'(D3_CYCLES - 1);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid && !angle_special) state_n = ST_PH_LO;
			ST_PH_LO:   state_n = ST_PH_HI;
			ST_PH_HI:   state_n = ST_INIT;
			ST_INIT:    state_n = ST_ITER;
			ST_ITER:    if (iter_last) state_n = ST_SCALE;
			ST_SCALE:   state_n = ST_MUL_C;
			ST_MUL_C:   state_n = ST_MUL_S;
			ST_MUL_S:   state_n = ST_D3_INIT;
			ST_D3_INIT: state_n = ST_DIV3;
			ST_DIV3:    if (d3_last) state_n = ST_SUM;
			ST_SUM:     state_n = ST_OUT;
			ST_OUT:     if (out_free) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		cmd.idx  = cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && !angle_special;
			end
			ST_PH_LO:   cmd.ph_lo = 1'b1;
			ST_PH_HI:   cmd.ph_hi = 1'b1;
			ST_INIT:    cmd.init = 1'b1;
			ST_ITER: begin
				cmd.cordic_en = 6'(cnt_q) < 6'(N_ROT);
				cmd.div_en    = 6'(cnt_q) < 6'(DIV_STEPS);
			end
			ST_SCALE:   cmd.scale = 1'b1;
			ST_MUL_C:   cmd.mul_c = 1'b1;
			ST_MUL_S:   cmd.mul_s = 1'b1;
			ST_D3_INIT: cmd.d3_init = 1'b1;
			ST_DIV3:    cmd.d3_step = 1'b1;
			ST_SUM:     cmd.sum = 1'b1;
			ST_OUT:     cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if ((state_q == ST_ITER && !iter_last) || (state_q == ST_DIV3 && !d3_last))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/asg_checker.sv =====
// ----------------------------------------------------------------------------
// asg_checker
// Port-level checks of the arrowhead segment generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arrowhead_segment_generator_defines.svh"

module asg_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire [2:0]   s_axis_tuser,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [95:0]  m_axis_tdata
);

	// a stalled result holds
	`ASG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// a real request occupies the block
	`ASG_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !s_axis_tready, "ready after a valid request")

	// a request with a special angle is dropped at once
	`ASG_ASSERT_NEXT(a_drop_special, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], s_axis_tready, "special angle not dropped")

endmodule

bind arrowhead_segment_generator asg_checker u_asg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
